[src/pft_pkg.sv]
// Package for the pose frame transform: widths, CORDIC angle table, command codes.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package pft_pkg;
  localparam int CORDIC_STAGES = 16;
  localparam int POS_WIDTH = 32;
  localparam int NSTG = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int SATW = (POS_WIDTH > 32) ? 32 : POS_WIDTH;
  localparam int CW = 44;          // 33-bit diff + 8 guard + growth
  localparam int QDEPTH = 2;

  typedef enum logic {CMD_L2G = 1'b0, CMD_G2L = 1'b1} cmd_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0] z;
    logic [31:0] rx;
    logic [31:0] ry;
    logic        l2g;
    logic [15:0] hd;
    logic [31:0] curv;
    logic [31:0] arc;
  } item_t;

  function automatic logic [31:0] atan_f(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000; 1: r = 32'h12E4051D; 2: r = 32'h09FB385B;
      3: r = 32'h051111D4; 4: r = 32'h028B0D43; 5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E; 7: r = 32'h00517C55; 8: r = 32'h0028BE53;
      9: r = 32'h00145F2E; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
      21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

[src/pft_front.sv]
// Front end: accept an item, classify by command, pre-rotate by quarter turns.
// Depends on pft_pkg.
`timescale 1ns / 1ps
module pft_front import pft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic signed [31:0] in_ref_x,
  input  logic signed [31:0] in_ref_y,
  input  logic [15:0] in_ref_heading,
  input  logic signed [31:0] in_tgt_x,
  input  logic signed [31:0] in_tgt_y,
  input  logic [15:0] in_tgt_heading,
  input  logic signed [31:0] in_tgt_curvature,
  input  logic [31:0] in_tgt_arc_length,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  logic        v_r;
  item_t       it_r;
  item_t       it_nxt;
  logic signed [32:0] dx, dy, px, py;
  logic [15:0] ang;
  logic [31:0] a, ru;
  logic [1:0]  q;
  logic        l2g;

  assign in_ready = !v_r || q_ready;
  assign q_valid = v_r;
  assign q_item = it_r;

  always_comb begin
    l2g = (cmd_t'(in_command) == CMD_L2G);
    if (l2g) begin
      dx = {in_tgt_x[31], in_tgt_x};
      dy = {in_tgt_y[31], in_tgt_y};
      ang = in_ref_heading;
    end else begin
      dx = {in_tgt_x[31], in_tgt_x} - {in_ref_x[31], in_ref_x};
      dy = {in_tgt_y[31], in_tgt_y} - {in_ref_y[31], in_ref_y};
      ang = 16'd0 - in_ref_heading;
    end
    a = {ang, 16'd0};
    q = 2'((a + 32'h20000000) >> 30);
    ru = a - {q, 30'd0};
    case (q)
      2'd1: begin px = -dy; py = dx; end
      2'd2: begin px = -dx; py = -dy; end
      2'd3: begin px = dy; py = -dx; end
      default: begin px = dx; py = dy; end
    endcase
    it_nxt.x = {{(CW-41){px[32]}}, px, 8'd0};
    it_nxt.y = {{(CW-41){py[32]}}, py, 8'd0};
    it_nxt.z = ru;
    it_nxt.rx = in_ref_x;
    it_nxt.ry = in_ref_y;
    it_nxt.l2g = l2g;
    it_nxt.hd = l2g ? in_ref_heading + in_tgt_heading : in_tgt_heading - in_ref_heading;
    it_nxt.curv = in_tgt_curvature;
    it_nxt.arc = l2g ? in_tgt_arc_length : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
    if (in_ready && in_valid) it_r <= it_nxt;
  end
endmodule

[src/pft_queue.sv]
// Short FIFO between front end and back end.
// Depends on pft_pkg.
`timescale 1ns / 1ps
module pft_queue import pft_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);
  item_t       mem_r [QDEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr, rd;

  assign wr_ready = (cnt_r != 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_item;
  end
endmodule

[src/pft_back.sv]
// Back end: CORDIC stage pipeline, gain multiply, offset add and saturation.
// Depends on pft_pkg.
`timescale 1ns / 1ps
module pft_back import pft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_valid,
  output logic        s_ready,
  input  item_t       s_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [15:0] out_heading,
  output logic signed [31:0] out_curvature,
  output logic [31:0] out_arc_length,
  output logic        out_saturated
);
  localparam int NP = NSTG + 3;
  logic        v_r [NP+1];
  item_t       st_r [NSTG+1];
  logic signed [CW+20:0] mx_r, my_r;
  item_t       m_r;
  logic signed [CW+20:0] rx_w, ry_w;
  logic signed [CW:0] sx_r, sy_r;
  item_t       f_r;
  logic        adv;

  // Whole pipe moves together; stall when the output register is held.
  assign adv = !v_r[NP] || out_ready;
  assign s_ready = adv;
  assign out_valid = v_r[NP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NP; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= s_valid;
      for (int k = 1; k <= NP; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) st_r[0] <= s_item;
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    item_t nx;
    logic signed [CW-1:0] xs, ys;
    always_comb begin
      nx = st_r[i];
      xs = $signed(st_r[i].x) >>> i;
      ys = $signed(st_r[i].y) >>> i;
      if (!st_r[i].z[31]) begin
        nx.x = st_r[i].x - ys; nx.y = st_r[i].y + xs; nx.z = st_r[i].z - atan_f(i);
      end else begin
        nx.x = st_r[i].x + ys; nx.y = st_r[i].y - xs; nx.z = st_r[i].z + atan_f(i);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st_r[i+1] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r <= $signed(st_r[NSTG].x) * $signed(21'sd636751) + (65'sd1 <<< 27);
      my_r <= $signed(st_r[NSTG].y) * $signed(21'sd636751) + (65'sd1 <<< 27);
      m_r <= st_r[NSTG];
    end
  end

  assign rx_w = mx_r >>> 28;
  assign ry_w = my_r >>> 28;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= rx_w[CW:0] + (m_r.l2g ? {{(CW-31){m_r.rx[31]}}, m_r.rx} : '0);
      sy_r <= ry_w[CW:0] + (m_r.l2g ? {{(CW-31){m_r.ry[31]}}, m_r.ry} : '0);
      f_r <= m_r;
    end
  end

  localparam logic signed [CW:0] HI = (CW+1)'((64'sd1 <<< (SATW-1)) - 1);
  localparam logic signed [CW:0] LO = -HI - 1;
  logic cx_hi, cx_lo, cy_hi, cy_lo;
  assign cx_hi = sx_r > HI; assign cx_lo = sx_r < LO;
  assign cy_hi = sy_r > HI; assign cy_lo = sy_r < LO;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= cx_hi ? HI[31:0] : cx_lo ? LO[31:0] : sx_r[31:0];
      out_y <= cy_hi ? HI[31:0] : cy_lo ? LO[31:0] : sy_r[31:0];
      out_saturated <= cx_hi | cx_lo | cy_hi | cy_lo;
      out_heading <= f_r.hd;
      out_curvature <= f_r.curv;
      out_arc_length <= f_r.arc;
    end
  end
endmodule

[src/pose_frame_transform.sv]
// Top level of the pose frame transform.
// Depends on pft_pkg, pft_front, pft_queue, pft_back.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: one pose pair plus a command per transfer (valid/ready).
//   Command local-to-global rotates the target by the reference heading and adds
//   the reference position; global-to-local subtracts, then rotates by the
//   negative heading. Headings wrap modulo one turn, positions saturate.
//   Output channel out_*: exactly one result per input transfer, in order.
//   Throughput: one item per cycle while out_ready stays high, set by the fully
//   pipelined CORDIC (one stage register per iteration).
//   Path from input transfer to out_valid: the front register loads on the
//   transfer edge; then queue, stage input, CORDIC stages, multiply, add,
//   saturate.
//   Reset: clears all valid flags and the queue pointers and count; data registers are not reset.
//   Stall: when the receiver drops out_ready with out_valid high the back pipe holds; the queue
//   absorbs in-flight items from the front, then in_ready falls.
module pose_frame_transform import pft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic signed [31:0] in_ref_x,
  input  logic signed [31:0] in_ref_y,
  input  logic [15:0] in_ref_heading,
  input  logic signed [31:0] in_tgt_x,
  input  logic signed [31:0] in_tgt_y,
  input  logic [15:0] in_tgt_heading,
  input  logic signed [31:0] in_tgt_curvature,
  input  logic [31:0] in_tgt_arc_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic [15:0] out_heading,
  output logic signed [31:0] out_curvature,
  output logic [31:0] out_arc_length,
  output logic        out_saturated
);
  logic  f_valid, f_ready, b_valid, b_ready;
  item_t f_item, b_item;

  // Classify and pre-rotate.
  pft_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_ref_x, .in_ref_y,
    .in_ref_heading, .in_tgt_x, .in_tgt_y, .in_tgt_heading, .in_tgt_curvature,
    .in_tgt_arc_length, .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  // Decouple front and back.
  pft_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  // Rotate, scale, offset, saturate.
  pft_back u_back (
    .clk, .rst_n, .s_valid(b_valid), .s_ready(b_ready), .s_item(b_item),
    .out_valid, .out_ready, .out_x, .out_y, .out_heading, .out_curvature,
    .out_arc_length, .out_saturated
  );
endmodule

[bench/pft_checker.sv]
// Result checker for the pose frame transform: predicts each result and compares.
// Depends on pft_pkg; watches the in_ and out_ channels of the block.
`timescale 1ns / 1ps
module pft_checker import pft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic signed [31:0] in_ref_x,
  input  logic signed [31:0] in_ref_y,
  input  logic [15:0] in_ref_heading,
  input  logic signed [31:0] in_tgt_x,
  input  logic signed [31:0] in_tgt_y,
  input  logic [15:0] in_tgt_heading,
  input  logic signed [31:0] in_tgt_curvature,
  input  logic [31:0] in_tgt_arc_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic [15:0] out_heading,
  input  logic signed [31:0] out_curvature,
  input  logic [31:0] out_arc_length,
  input  logic        out_saturated,
  output int          fail_count,
  output int          pending
);
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0] hd;
    logic signed [31:0] curv;
    logic [31:0] arc;
    logic sat;
  } pose_t;

  pose_t pose_q[$];

  // Arithmetic shift right with floor.
  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [31:0] clip(longint v, ref logic hit);
    longint hi, lo;
    hi = (longint'(1) <<< (SATW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi[31:0];
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  function automatic void spin(longint xi, longint yi, logic [15:0] ang,
                               output longint rx, output longint ry);
    logic [31:0] a, ru, q;
    longint x, y, z, t, xs, ys, tab;
    a = {ang, 16'h0};
    q = ((a + 32'h20000000) >> 30) & 32'd3;
    ru = a - (q << 30);
    z = longint'($signed(ru));
    x = xi;
    y = yi;
    case (q)
      1: begin t = x; x = -y; y = t; end
      2: begin x = -x; y = -y; end
      3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < NSTG; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      case (i)
        0: tab = 'h20000000; 1: tab = 'h12E4051D; 2: tab = 'h09FB385B;
        3: tab = 'h051111D4; 4: tab = 'h028B0D43; 5: tab = 'h0145D7E1;
        6: tab = 'h00A2F61E; 7: tab = 'h00517C55; 8: tab = 'h0028BE53;
        9: tab = 'h00145F2E; 10: tab = 'h000A2F98; 11: tab = 'h000517CC;
        12: tab = 'h00028BE6; 13: tab = 'h000145F3; 14: tab = 'h0000A2F9;
        15: tab = 'h0000517C; 16: tab = 'h000028BE; 17: tab = 'h0000145F;
        18: tab = 'h00000A2F; 19: tab = 'h00000517; 20: tab = 'h0000028B;
        21: tab = 'h00000145; 22: tab = 'h000000A2; default: tab = 'h00000051;
      endcase
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - tab;
      end else begin
        x = x + ys; y = y - xs; z = z + tab;
      end
    end
    rx = asr(x * 636751 + (longint'(1) <<< 27), 28);
    ry = asr(y * 636751 + (longint'(1) <<< 27), 28);
  endfunction

  function automatic pose_t transform_pose();
    pose_t p;
    longint ox, oy;
    logic hit;
    hit = 1'b0;
    p.curv = in_tgt_curvature;
    if (cmd_t'(in_command) == CMD_L2G) begin
      spin(longint'(in_tgt_x), longint'(in_tgt_y), in_ref_heading, ox, oy);
      ox = ox + longint'(in_ref_x);
      oy = oy + longint'(in_ref_y);
      p.hd = in_ref_heading + in_tgt_heading;
      p.arc = in_tgt_arc_length;
    end else begin
      spin(longint'(in_tgt_x) - longint'(in_ref_x),
           longint'(in_tgt_y) - longint'(in_ref_y), 16'(-in_ref_heading), ox, oy);
      p.hd = in_tgt_heading - in_ref_heading;
      p.arc = '0;
    end
    p.x = clip(ox, hit);
    p.y = clip(oy, hit);
    p.sat = hit;
    return p;
  endfunction

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      fail_count <= 0;
      pose_q.delete();
    end else begin
      if (in_valid && in_ready) pose_q.push_back(transform_pose());
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = pose_q.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_heading !== e.hd ||
              out_curvature !== e.curv || out_arc_length !== e.arc ||
              out_saturated !== e.sat) begin
            fail_count <= fail_count + 1;
            if (out_x !== e.x) $error("out_x exp %0d got %0d", e.x, out_x);
            if (out_y !== e.y) $error("out_y exp %0d got %0d", e.y, out_y);
            if (out_heading !== e.hd)
              $error("out_heading exp %0d got %0d", e.hd, out_heading);
            if (out_curvature !== e.curv)
              $error("out_curvature exp %0d got %0d", e.curv, out_curvature);
            if (out_arc_length !== e.arc)
              $error("out_arc_length exp %0d got %0d", e.arc, out_arc_length);
            if (out_saturated !== e.sat)
              $error("out_saturated exp %0b got %0b", e.sat, out_saturated);
          end
        end
      end
    end
  end
endmodule

[bench/testbench.sv]
// Top of the pose frame transform bench: clock, reset, stimulus, verdict.
// Depends on pft_pkg, pose_frame_transform and pft_checker.
`timescale 1ns / 1ps
module testbench;
  import pft_pkg::*;

  localparam int RANDOM_ITEMS = 630;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = CORDIC_STAGES + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic signed [31:0] in_ref_x = '0, in_ref_y = '0, in_tgt_x = '0, in_tgt_y = '0;
  logic [15:0] in_ref_heading = '0, in_tgt_heading = '0;
  logic signed [31:0] in_tgt_curvature = '0;
  logic [31:0] in_tgt_arc_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_curvature;
  logic [15:0] out_heading;
  logic [31:0] out_arc_length;
  logic out_saturated;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;   // set by stimulus to request a long receiver stall

  always #10 clk = ~clk;

  pose_frame_transform u_dut (.*);

  pft_checker u_chk (.*);

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else if (in_valid || pending != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Receiver: random stall pattern with ready high most of the time, one long hold-off.
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 99);
      out_ready <= (mode < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
      default: return $urandom();
    endcase
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_pose(logic cmd, logic signed [31:0] rx, ry, logic [15:0] rh,
                           logic signed [31:0] tx, ty, logic [15:0] th,
                           logic signed [31:0] cv, logic [31:0] arc);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_ref_x <= rx; in_ref_y <= ry; in_ref_heading <= rh;
    in_tgt_x <= tx; in_tgt_y <= ty; in_tgt_heading <= th;
    in_tgt_curvature <= cv; in_tgt_arc_length <= arc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] mx, mn;
    int burst;
    bit held, drained;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    held = 1'b0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every quarter, both commands, field extremes, clipping cases.
    send_pose(CMD_L2G, 0, 0, 16'h0000, 32'sh10000, 0, 16'h0000, 0, 0);
    send_pose(CMD_L2G, 0, 0, 16'h4000, 32'sh10000, 0, 16'h1234, 1, 5);
    send_pose(CMD_L2G, 0, 0, 16'h8000, 32'sh10000, 32'sh20000, 16'hFFFF, -1, 7);
    send_pose(CMD_L2G, 0, 0, 16'hC000, 32'sh10000, 32'sh20000, 16'h8000, mx, '1);
    send_pose(CMD_L2G, 0, 0, 16'hE000, 32'sh30000, 32'sh10000, 16'h2000, mn, '1);
    send_pose(CMD_L2G, 0, 0, 16'h2000, 32'sh30000, -32'sh10000, 16'hFFFF, 0, 0);
    send_pose(CMD_L2G, mx, mx, 16'h0000, mx, mx, 16'hFFFF, mx, '1);
    send_pose(CMD_L2G, mn, mn, 16'h0000, mn, mn, 16'h0001, mn, 0);
    send_pose(CMD_L2G, mx, mn, 16'h4000, mn, mx, 16'h7FFF, 0, '1);
    send_pose(CMD_L2G, mn, mn, 16'hFFFF, mx, mn, 16'hFFFF, -1, '1);
    send_pose(CMD_G2L, 0, 0, 16'h0000, 32'sh10000, 0, 16'h0000, 3, '1);
    send_pose(CMD_G2L, 32'sh10000, 0, 16'h4000, 32'sh20000, 32'sh10000, 16'h0001, 3, 9);
    send_pose(CMD_G2L, 0, 0, 16'h8000, 32'sh10000, 32'sh20000, 16'h0000, 0, '1);
    send_pose(CMD_G2L, 0, 0, 16'hC000, -32'sh10000, 32'sh20000, 16'hC000, 0, 1);
    send_pose(CMD_G2L, mn, mn, 16'h0000, mx, mx, 16'h0000, mx, '1);
    send_pose(CMD_G2L, mx, mx, 16'h0000, mn, mn, 16'hFFFF, mn, '1);
    send_pose(CMD_G2L, mn, mx, 16'h2000, mx, mn, 16'h8000, -1, '1);
    send_pose(CMD_G2L, mx, mn, 16'hFFFF, mn, mx, 16'h0000, 0, 0);
    send_pose(CMD_G2L, mn, mn, 16'h6000, mn, mn, 16'hFFFF, 0, 0);
    idle_sender(1);

    // Random part in bursts; a long receiver hold-off and a full drain midway.
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      if (n >= 200 && !held) begin
        hold_off = 1'b1;
        held = 1'b1;
      end
      if (n >= 400 && !drained) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        drained = 1'b1;
      end
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
        send_pose(1'($urandom_range(0, 1)), pick_pos(), pick_pos(), 16'($urandom()),
                  pick_pos(), pick_pos(), 16'($urandom()), $urandom(), $urandom());
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule

[filelist.f]
src/pft_pkg.sv
src/pft_front.sv
src/pft_queue.sv
src/pft_back.sv
src/pose_frame_transform.sv
bench/pft_checker.sv
bench/testbench.sv
